// ===== src/fpas_pkg.sv =====
// Shared types and constants for the binary32 add/subtract pipeline.
package fpas_pkg;

    localparam int unsigned PIPE_STAGES = 4;
    localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
    localparam logic [7:0] EXP_MAX = 8'hFF;

    // Aligned operands, handed from the align stage to the add stage.
    typedef struct packed {
        logic        special;
        logic [31:0] special_bits;
        logic        sign;
        logic        subtract;
        logic [7:0]  exp;
        logic [26:0] mant_a;
        logic [26:0] mant_b;
    } align_t;

    // Raw sum, handed from the add stage to the normalize stage.
    typedef struct packed {
        logic        special;
        logic [31:0] special_bits;
        logic        sign;
        logic        zero;
        logic [8:0]  exp;
        logic [27:0] sum;
    } sum_t;

    // Normalized value, handed to the rounding stage.
    typedef struct packed {
        logic        special;
        logic [31:0] special_bits;
        logic        sign;
        logic [8:0]  exp;
        logic [26:0] mant;
    } norm_t;

endpackage

// ===== src/float32_add_subtract.sv =====
// IEEE 754 binary32 adder/subtracter with round-to-nearest-even, pipelined.
//
// Input channel: s_valid/s_ready with s_operation (0 adds, 1 computes a - b),
// s_operand_a and s_operand_b as raw binary32 patterns. Result channel:
// m_valid/m_ready with m_result_bits. Every accepted transaction gives one
// result, in order. NaN results are the canonical quiet NaN 0x7FC00000.
//
// The datapath has four register stages: unpack and align, add, normalize,
// and round and pack. The accepting edge loads the first stage, and the
// result passes the add, normalize and round registers on to m_valid; a new
// transaction can enter every cycle while m_ready does not stall the flow.
// The normalize stage sets the clock: a leading-zero count and a shift
// over 27 bits.
//
// A synchronous active-low reset on aresetn empties the pipeline. When the
// receiver holds m_ready low, the stages fill up behind the result and
// s_ready drops only once every stage holds a transaction; nothing is lost
// or repeated, and the flow resumes at full rate when m_ready returns.
module float32_add_subtract (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [31:0] s_operand_a,
    input  logic [31:0] s_operand_b,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_result_bits
);
    import fpas_pkg::*;

    logic   v1_reg, v2_reg, v3_reg, v4_reg;
    logic   en1, en2, en3, en4;
    align_t s1_reg, s1_next;
    sum_t   s2_reg, s2_next;
    norm_t  s3_reg, s3_next;
    logic [31:0] s4_reg, s4_next;

    // Each stage advances when it is empty or the stage after it moves.
    assign en4     = !v4_reg || m_ready;
    assign en3     = !v3_reg || en4;
    assign en2     = !v2_reg || en3;
    assign en1     = !v1_reg || en2;
    assign s_ready = en1;
    assign m_valid = v4_reg;
    assign m_result_bits = s4_reg;

    // Stage 1: special cases, operand order and alignment.
    always_comb begin
        logic [31:0] a, b, t;
        logic [7:0]  ea, eb, d;
        logic [26:0] ma, mb, sh;
        logic        a_nan, b_nan, a_inf, b_inf, stk;
        a = s_operand_a;
        b = s_operand_b ^ {s_operation, 31'd0};
        t = '0;
        stk = 1'b0;
        a_nan = (a[30:23] == EXP_MAX) && (a[22:0] != 23'd0);
        b_nan = (b[30:23] == EXP_MAX) && (b[22:0] != 23'd0);
        a_inf = (a[30:23] == EXP_MAX) && (a[22:0] == 23'd0);
        b_inf = (b[30:23] == EXP_MAX) && (b[22:0] == 23'd0);
        s1_next = '0;
        if (a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]))) begin
            s1_next.special = 1'b1;
            s1_next.special_bits = QNAN_BITS;
        end else if (a_inf) begin
            s1_next.special = 1'b1;
            s1_next.special_bits = a;
        end else if (b_inf) begin
            s1_next.special = 1'b1;
            s1_next.special_bits = b;
        end
        if (b[30:0] > a[30:0]) begin
            t = a;
            a = b;
            b = t;
        end
        ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma = {(a[30:23] != 8'd0), a[22:0], 3'b000};
        mb = {(b[30:23] != 8'd0), b[22:0], 3'b000};
        d  = ea - eb;
        if (d > 8'd26) begin
            sh = {26'd0, (mb != 27'd0)};
        end else begin
            sh  = mb >> d[4:0];
            stk = ((mb & ~(27'h7FF_FFFF << d[4:0])) != 27'd0);
            sh[0] = sh[0] | stk;
        end
        s1_next.sign     = a[31];
        s1_next.subtract = a[31] ^ b[31];
        s1_next.exp      = ea;
        s1_next.mant_a   = ma;
        s1_next.mant_b   = sh;
    end

    // Stage 2: the wide add or subtract.
    always_comb begin
        s2_next.special      = s1_reg.special;
        s2_next.special_bits = s1_reg.special_bits;
        s2_next.sign         = s1_reg.sign;
        s2_next.exp          = {1'b0, s1_reg.exp};
        if (s1_reg.subtract) begin
            s2_next.sum = {1'b0, s1_reg.mant_a} - {1'b0, s1_reg.mant_b};
        end else begin
            s2_next.sum = {1'b0, s1_reg.mant_a} + {1'b0, s1_reg.mant_b};
        end
        s2_next.zero = s1_reg.subtract && (s1_reg.mant_a == s1_reg.mant_b);
    end

    // Stage 3: normalize. A carry shifts right once; cancellation shifts left
    // by the leading-zero count, but never below the smallest exponent.
    always_comb begin
        logic [4:0]  lz, sh;
        logic [26:0] m;
        lz = 5'd27;
        sh = 5'd0;
        m  = '0;
        for (int i = 0; i < 27; i++) begin
            if (s2_reg.sum[i]) begin
                lz = 5'(26 - i);
            end
        end
        // An infinity or NaN outranks an exact cancellation.
        s3_next.special      = s2_reg.special;
        s3_next.special_bits = s2_reg.special ? s2_reg.special_bits : 32'd0;
        if (s2_reg.zero) begin
            s3_next.special = 1'b1;
        end
        s3_next.sign = s2_reg.sign;
        if (s2_reg.sum[27]) begin
            s3_next.mant = s2_reg.sum[27:1] | {26'd0, s2_reg.sum[0]};
            s3_next.exp  = s2_reg.exp + 9'd1;
        end else begin
            if ({4'd0, lz} < s2_reg.exp) begin
                sh = lz;
            end else begin
                sh = 5'(s2_reg.exp - 9'd1);
            end
            m = s2_reg.sum[26:0] << sh;
            s3_next.mant = m;
            s3_next.exp  = s2_reg.exp - {4'd0, sh};
        end
    end

    // Stage 4: round to nearest even and pack.
    always_comb begin
        logic [24:0] r;
        logic [8:0]  e;
        logic [2:0]  low;
        low = s3_reg.mant[2:0];
        r   = {1'b0, s3_reg.mant[26:3]};
        if (low > 3'd4 || (low == 3'd4 && r[0])) begin
            r = r + 25'd1;
        end
        e = s3_reg.exp;
        if (r[24]) begin
            r = r >> 1;
            e = e + 9'd1;
        end
        if (s3_reg.special) begin
            s4_next = s3_reg.special_bits;
        end else if (e >= 9'd255) begin
            s4_next = {s3_reg.sign, EXP_MAX, 23'd0};
        end else if (!r[23]) begin
            s4_next = {s3_reg.sign, 8'd0, r[22:0]};
        end else begin
            s4_next = {s3_reg.sign, e[7:0], r[22:0]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else begin
            if (en1) v1_reg <= s_valid;
            if (en2) v2_reg <= v1_reg;
            if (en3) v3_reg <= v2_reg;
            if (en4) v4_reg <= v3_reg;
        end
        if (en1) s1_reg <= s1_next;
        if (en2) s2_reg <= s2_next;
        if (en3) s3_reg <= s3_next;
        if (en4) s4_reg <= s4_next;
    end

endmodule
